[sv/ewed_pkg.sv]
`timescale 1ns / 1ps

package ewed_pkg;

  localparam int ENERGY_W  = 48;
  localparam int RATE_W    = 16;
  localparam int SHIFT_W   = 3;
  localparam int SILENCE_W = 8;
  localparam int MINW_W    = 7;
  localparam int SLOT_W    = 6;
  localparam int FRAMES_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = ENERGY_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_RATE   = 3'd0,
    CFG_GATE_SHIFT   = 3'd1,
    CFG_GATE_FLOOR   = 3'd2,
    CFG_SILENCE_END  = 3'd3,
    CFG_MIN_WORD     = 3'd4
  } cfg_idx_e;

  localparam logic [RATE_W-1:0]    NOISE_RATE_RST  = 16'd3277;
  localparam logic [SHIFT_W-1:0]   GATE_SHIFT_RST  = 3'd2;
  localparam logic [ENERGY_W-1:0]  GATE_FLOOR_RST  = 48'd7;
  localparam logic [SILENCE_W-1:0] SILENCE_END_RST = 8'd12;
  localparam logic [MINW_W-1:0]    MIN_WORD_RST    = 7'd8;

  typedef struct packed {
    logic [SILENCE_W-1:0] silence_end_frames;
    logic [MINW_W-1:0]    min_word_frames;
  } seg_cfg_t;

  typedef struct packed {
    logic                 is_speech;
    logic                 frame_stored;
    logic [SLOT_W-1:0]    slot_index;
    logic                 word_done;
    logic [FRAMES_W-1:0]  word_frames;
    logic                 word_accepted;
  } result_t;

endpackage

[sv/ewed_if.sv]
`timescale 1ns / 1ps

interface ewed_in_if;
  logic                           valid;
  logic                           ready;
  logic [ewed_pkg::ENERGY_W-1:0]  frame_energy;

  modport source (output valid, output frame_energy, input ready);
  modport sink   (input valid, input frame_energy, output ready);
endinterface

interface ewed_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_speech;
  logic                           frame_stored;
  logic [ewed_pkg::SLOT_W-1:0]    slot_index;
  logic                           word_done;
  logic [ewed_pkg::FRAMES_W-1:0]  word_frames;
  logic                           word_accepted;

  modport source (output valid, output is_speech, output frame_stored, output slot_index,
                  output word_done, output word_frames, output word_accepted, input ready);
  modport sink   (input valid, input is_speech, input frame_stored, input slot_index,
                  input word_done, input word_frames, input word_accepted, output ready);
endinterface

[sv/ewed_floor.sv]
`timescale 1ns / 1ps

module ewed_floor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             advance_i,
  input  logic [ewed_pkg::ENERGY_W-1:0]    energy_i,
  input  logic [ewed_pkg::RATE_W-1:0]      noise_rate_i,
  input  logic [ewed_pkg::SHIFT_W-1:0]     gate_shift_i,
  input  logic [ewed_pkg::ENERGY_W-1:0]    gate_floor_i,
  output logic                             speech_o
);

  localparam int EW   = ewed_pkg::ENERGY_W;
  localparam int RW   = ewed_pkg::RATE_W;
  localparam int SHW  = (1 << ewed_pkg::SHIFT_W) - 1;

  logic [EW-1:0]      floor_q, floor_d;
  logic [EW-1:0]      diff;
  logic [EW+RW-1:0]   prod;
  logic [EW+SHW-1:0]  shifted;
  logic [EW-1:0]      gate_sat, gate;

  // Take energy on a zero floor or a lower one, else step up by rate/65536.
  always_comb begin
    diff = energy_i - floor_q;
    prod = {{RW{1'b0}}, diff} * {{EW{1'b0}}, noise_rate_i};
    if ((floor_q == '0) || (energy_i < floor_q)) begin
      floor_d = energy_i;
    end else begin
      floor_d = floor_q + prod[EW+RW-1:RW];
    end
  end

  // Gate uses the updated floor, saturated at full scale, clamped from below.
  always_comb begin
    shifted  = {{SHW{1'b0}}, floor_d} << gate_shift_i;
    gate_sat = (shifted[EW+SHW-1:EW] != '0) ? '1 : shifted[EW-1:0];
    gate     = (gate_sat < gate_floor_i) ? gate_floor_i : gate_sat;
    speech_o = energy_i > gate;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= '0;
    end else if (advance_i) begin
      floor_q <= floor_d;
    end
  end

endmodule

[sv/ewed_seg.sv]
`timescale 1ns / 1ps

module ewed_seg #(
  parameter int MAX_FRAMES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 speech_i,
  input  ewed_pkg::seg_cfg_t   cfg_i,
  output ewed_pkg::result_t    result_o
);

  localparam int LEN_W = $clog2(MAX_FRAMES + 1);
  localparam int CW    = (LEN_W > ewed_pkg::FRAMES_W) ? LEN_W : ewed_pkg::FRAMES_W;
  localparam int QW    = ewed_pkg::SILENCE_W;

  logic             in_word_q, in_word_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [QW-1:0]    quiet_q, quiet_d;

  logic             active, stored, done;
  logic [LEN_W-1:0] len_cur, len_nxt;
  logic [QW-1:0]    quiet_cur, quiet_nxt;
  logic [CW-1:0]    len_cur_x, len_nxt_x;

  always_comb begin
    active    = in_word_q | speech_i;
    len_cur   = in_word_q ? len_q : '0;
    quiet_cur = in_word_q ? quiet_q : '0;

    if (speech_i) begin
      quiet_nxt = '0;
    end else if (quiet_cur != '1) begin
      quiet_nxt = quiet_cur + 1'b1;
    end else begin
      quiet_nxt = quiet_cur;
    end

    stored  = len_cur < LEN_W'(MAX_FRAMES);
    len_nxt = stored ? len_cur + 1'b1 : len_cur;
    done    = (len_nxt >= LEN_W'(MAX_FRAMES)) || (quiet_nxt >= cfg_i.silence_end_frames);

    len_cur_x = CW'(len_cur);
    len_nxt_x = CW'(len_nxt);

    result_o.is_speech     = speech_i;
    result_o.frame_stored  = active & stored;
    result_o.slot_index    = (active & stored) ? len_cur_x[ewed_pkg::SLOT_W-1:0] : '0;
    result_o.word_done     = active & done;
    result_o.word_frames   = (active & done) ? len_nxt_x[ewed_pkg::FRAMES_W-1:0] : '0;
    result_o.word_accepted = active & done & (len_nxt_x >= CW'(cfg_i.min_word_frames));

    // Frames outside a word with no speech leave the word state alone.
    in_word_d = in_word_q;
    len_d     = len_q;
    quiet_d   = quiet_q;
    if (active) begin
      in_word_d = ~done;
      len_d     = done ? '0 : len_nxt;
      quiet_d   = done ? '0 : quiet_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      len_q     <= '0;
      quiet_q   <= '0;
    end else if (advance_i) begin
      in_word_q <= in_word_d;
      len_q     <= len_d;
      quiet_q   <= quiet_d;
    end
  end

endmodule

[sv/energy_word_endpoint_detector.sv]
`timescale 1ns / 1ps
// Pipeline: a frame taken into the input register passes through one pass of
// floor, gate and word logic into the output register.
// Throughput: one frame per cycle while the output register is free or drained, set
// by the single floor and word register update; a waiting result stalls the input.
// Reset (rst_ni, async, active low): floor, word state and valid flags clear, config registers take defaults.

module energy_word_endpoint_detector #(
  parameter int MAX_FRAMES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ewed_in_if.sink                            in_i,
  ewed_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [ewed_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ewed_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // Configuration registers.
  logic [ewed_pkg::RATE_W-1:0]    noise_rate_q;
  logic [ewed_pkg::SHIFT_W-1:0]   gate_shift_q;
  logic [ewed_pkg::ENERGY_W-1:0]  gate_floor_q;
  ewed_pkg::seg_cfg_t             seg_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_rate_q                 <= ewed_pkg::NOISE_RATE_RST;
      gate_shift_q                 <= ewed_pkg::GATE_SHIFT_RST;
      gate_floor_q                 <= ewed_pkg::GATE_FLOOR_RST;
      seg_cfg_q.silence_end_frames <= ewed_pkg::SILENCE_END_RST;
      seg_cfg_q.min_word_frames    <= ewed_pkg::MIN_WORD_RST;
    end else if (cfg_we_i) begin
      case (ewed_pkg::cfg_idx_e'(cfg_idx_i))
        ewed_pkg::CFG_NOISE_RATE: begin
          noise_rate_q <= cfg_data_i[ewed_pkg::RATE_W-1:0];
        end
        ewed_pkg::CFG_GATE_SHIFT: begin
          gate_shift_q <= cfg_data_i[ewed_pkg::SHIFT_W-1:0];
        end
        ewed_pkg::CFG_GATE_FLOOR: begin
          gate_floor_q <= cfg_data_i[ewed_pkg::ENERGY_W-1:0];
        end
        ewed_pkg::CFG_SILENCE_END: begin
          seg_cfg_q.silence_end_frames <= cfg_data_i[ewed_pkg::SILENCE_W-1:0];
        end
        ewed_pkg::CFG_MIN_WORD: begin
          seg_cfg_q.min_word_frames <= cfg_data_i[ewed_pkg::MINW_W-1:0];
        end
        default: begin
          // Unmapped index: drop the write.
        end
      endcase
    end
  end

  // Input register: holds one frame until the processing pass can retire it.
  logic                           in_valid_q;
  logic [ewed_pkg::ENERGY_W-1:0]  energy_q;
  logic                           advance;
  logic                           out_valid_q;
  ewed_pkg::result_t              result, result_q;
  logic                           speech;

  // Advance when a frame waits and the output register is free or being drained.
  assign advance    = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      energy_q <= in_i.frame_energy;
    end
  end

  // Noise floor tracking and the speech gate.
  ewed_floor u_floor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .energy_i     (energy_q),
    .noise_rate_i (noise_rate_q),
    .gate_shift_i (gate_shift_q),
    .gate_floor_i (gate_floor_q),
    .speech_o     (speech)
  );

  // Word segmentation on the speech decision.
  ewed_seg #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_seg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .speech_i  (speech),
    .cfg_i     (seg_cfg_q),
    .result_o  (result)
  );

  // Output register: hold a result until its transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.is_speech     = result_q.is_speech;
  assign out_o.frame_stored  = result_q.frame_stored;
  assign out_o.slot_index    = result_q.slot_index;
  assign out_o.word_done     = result_q.word_done;
  assign out_o.word_frames   = result_q.word_frames;
  assign out_o.word_accepted = result_q.word_accepted;

endmodule
